// ----- hdl/mns_pkg.sv -----
// ----------------------------------------------------------------------------
// Melody note sequencer package
// Shared request/response types, codes and sizing constants.
// ----------------------------------------------------------------------------
package mns_pkg;

  // Song memory sizing
  localparam int unsigned SongDepth = 64;
  localparam int unsigned AddrW     = $clog2(SongDepth);
  localparam int unsigned CntW      = $clog2(SongDepth + 1);

  // Timing constants
  localparam int unsigned MsPerMinute = 60000;
  localparam int unsigned QuotW       = 16;
  localparam int unsigned TempoW      = 10;
  localparam int unsigned TempoReset  = 120;
  localparam int unsigned QuarterMsReset = MsPerMinute / TempoReset;
  localparam int unsigned SongLenReset   = 1;
  localparam int unsigned HoldReset      = 100;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTempo   = 2'd0,
    CfgSongLen = 2'd1,
    CfgHold    = 2'd2,
    CfgUnused  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ModeLoad = 2'd0,
    ModeTick = 2'd1,
    ModeStop = 2'd2,
    ModeNote = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e       mode;
    logic [5:0]  entry_slot;
    logic [12:0] note_base;
    logic [3:0]  octave_factor;
    logic [7:0]  length_quarters;
  } req_t;

  typedef struct packed {
    logic        start_tone;
    logic        silence;
    logic [16:0] tone_hz;
    logic [21:0] tone_ms;
    logic [5:0]  played_slot;
  } rsp_t;

  // One stored song entry
  typedef struct packed {
    logic [7:0]  len;
    logic [3:0]  oct;
    logic [12:0] base;
  } entry_t;

endpackage

// ----- hdl/mns_div.sv -----
// ----------------------------------------------------------------------------
// Quarter-note divider
// Restoring divider that forms 60000 / tempo, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mns_div import mns_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [TempoW-1:0] divisor_i,
  output logic              busy_o,
  output logic [QuotW-1:0]  quot_o
);

  localparam int unsigned StepW = $clog2(QuotW);

  logic              busy_q, busy_d;
  logic [StepW-1:0]  step_q, step_d;
  logic [TempoW-1:0] dvs_q, dvs_d;
  logic [TempoW-1:0] rem_q, rem_d;
  logic [QuotW-1:0]  quo_q, quo_d;
  logic [TempoW:0]   trial;
  logic              fits;

  // Shift the next dividend bit into the partial remainder and try a subtract
  assign trial = {rem_q, quo_q[QuotW-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = StepW'(QuotW - 1);
      dvs_d  = (divisor_i == '0) ? TempoW'(1) : divisor_i;
      rem_d  = '0;
      quo_d  = QuotW'(MsPerMinute);
    end else if (busy_q) begin
      rem_d  = fits ? TempoW'(trial - {1'b0, dvs_q}) : trial[TempoW-1:0];
      quo_d  = {quo_q[QuotW-2:0], fits};
      step_d = step_q - StepW'(1);
      if (step_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      dvs_q  <= TempoW'(TempoReset);
      rem_q  <= '0;
      quo_q  <= QuotW'(QuarterMsReset);
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
      dvs_q  <= dvs_d;
      rem_q  <= rem_d;
      quo_q  <= quo_d;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;

endmodule

// ----- hdl/melody_note_sequencer.sv -----
// ----------------------------------------------------------------------------
// Melody note sequencer
// Steps through a stored song on millisecond ticks and issues tone commands.
// ----------------------------------------------------------------------------
//  channel | signals                                           | direction
//  --------+---------------------------------------------------+------------------
//  in      | in_valid_i, in_stall_o, in_req_i                  | request in
//  out     | out_valid_o, out_stall_i, out_rsp_o               | response out
//  cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i | register write in
//
// A load ends when accepted; stop and single note pass through the emit state
// (a rest note does not). A tick while a note is current runs song memory read,
// length multiply, threshold compare and a second read on an advance, and only
// the new-note step when it starts the song; the output register may also wait
// on out_stall_i. A tempo write runs the divider; requests and further writes
// wait meanwhile. Writes wait until no request is in work, and a pending write
// holds off requests. Reset needs no clearing pass: song entries are undefined
// until loaded. One request is in work at a time.
// ----------------------------------------------------------------------------
module melody_note_sequencer import mns_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  req_t                in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rsp_t                out_rsp_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  typedef enum logic [2:0] {
    StIdle,
    StCurMul,
    StCurScale,
    StCurCmp,
    StNewMul,
    StEmit
  } state_e;

  // Control state
  state_e            state_q, state_d;
  logic [TempoW-1:0] tempo_q, tempo_d;
  logic [6:0]        song_len_q, song_len_d;
  logic [15:0]       hold_q, hold_d;
  logic              pos_valid_q, pos_valid_d;
  logic [AddrW-1:0]  pos_q, pos_d;
  logic [21:0]       elapsed_q, elapsed_d;
  logic              out_valid_q, out_valid_d;
  rsp_t              out_rsp_q, out_rsp_d;

  // Datapath registers
  entry_t            rd_data_q;
  logic [23:0]       len_prod_q;
  logic [26:0]       a19_q, e20_q;
  rsp_t              res_q, res_d;

  // Song memory
  entry_t            song_mem [SongDepth];
  logic [AddrW-1:0]  rd_addr;
  logic              wr_en;

  logic              in_accept, cfg_accept;
  logic              div_start, div_busy;
  logic [QuotW-1:0]  quarter_ms;
  logic [CntW-1:0]   used_len, pos_ext, pos_inc;
  logic [AddrW-1:0]  pos_eff, pos_next;
  logic [23:0]       len_prod;
  logic [16:0]       hz_prod;
  logic [21:0]       note_len;

  mns_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (tempo_d),
    .busy_o    (div_busy),
    .quot_o    (quarter_ms)
  );

  // Handshakes: hold off requests while a write is pending, writes while busy
  assign in_stall_o  = (state_q != StIdle) || div_busy || cfg_valid_i;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = !div_busy && (state_q == StIdle);
  assign cfg_accept  = cfg_valid_i && cfg_ready_o;
  assign div_start   = cfg_accept && (cfg_index_i == CfgTempo);

  // Clamp song length into 1..SongDepth and wrap positions against it
  always_comb begin
    if (song_len_q == '0) begin
      used_len = CntW'(1);
    end else if (CntW'(song_len_q) > CntW'(SongDepth)) begin
      used_len = CntW'(SongDepth);
    end else begin
      used_len = CntW'(song_len_q);
    end
  end

  assign pos_ext  = CntW'(pos_q);
  assign pos_eff  = (pos_ext >= used_len) ? '0 : pos_q;
  assign pos_inc  = pos_ext + CntW'(1);
  assign pos_next = (pos_inc >= used_len) ? '0 : pos_q + AddrW'(1);

  // Entry arithmetic on the word just read
  assign len_prod = 24'(quarter_ms) * 24'(rd_data_q.len);
  assign hz_prod  = 17'(rd_data_q.base) * 17'(rd_data_q.oct);
  assign note_len = len_prod[23:2];

  assign wr_en = in_accept && (in_req_i.mode == ModeLoad)
                 && (CntW'(in_req_i.entry_slot) < CntW'(SongDepth));

  // Sequencer
  always_comb begin
    state_d     = state_q;
    tempo_d     = tempo_q;
    song_len_d  = song_len_q;
    hold_d      = hold_q;
    pos_valid_d = pos_valid_q;
    pos_d       = pos_q;
    elapsed_d   = elapsed_q;
    out_valid_d = out_valid_q;
    out_rsp_d   = out_rsp_q;
    res_d       = res_q;
    rd_addr     = pos_eff;

    // Register writes
    if (cfg_accept) begin
      case (cfg_index_i)
        CfgTempo:   tempo_d    = cfg_data_i[TempoW-1:0];
        CfgSongLen: song_len_d = cfg_data_i[6:0];
        CfgHold:    hold_d     = cfg_data_i;
        default:    ;
      endcase
    end

    // Drop the response once taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (!pos_valid_q) begin
          rd_addr = '0;
        end
        if (in_accept) begin
          case (in_req_i.mode)
            ModeLoad: ;
            ModeStop: begin
              pos_valid_d = 1'b0;
              elapsed_d   = '0;
              res_d       = '0;
              res_d.silence = 1'b1;
              state_d     = StEmit;
            end
            ModeNote: begin
              res_d             = '0;
              res_d.start_tone  = 1'b1;
              res_d.tone_hz     = 17'(in_req_i.note_base) * 17'(in_req_i.octave_factor);
              res_d.tone_ms     = 22'(hold_q);
              if (in_req_i.note_base != '0 && in_req_i.octave_factor != '0) begin
                state_d = StEmit;
              end
            end
            ModeTick: begin
              // Advance the timer, then start the song or check the note
              if (elapsed_q != '1) begin
                elapsed_d = elapsed_q + 22'd1;
              end
              if (!pos_valid_q) begin
                pos_d       = '0;
                pos_valid_d = 1'b1;
                elapsed_d   = '0;
                state_d     = StNewMul;
              end else begin
                pos_d   = pos_eff;
                state_d = StCurMul;
              end
            end
            default: ;
          endcase
        end
      end
      StCurMul: begin
        state_d = StCurScale;
      end
      StCurScale: begin
        state_d = StCurCmp;
      end
      StCurCmp: begin
        // Elapsed beyond 95 percent of the length: move to the next entry
        rd_addr = pos_next;
        if (e20_q > a19_q) begin
          pos_d     = pos_next;
          elapsed_d = '0;
          state_d   = StNewMul;
        end else begin
          state_d = StIdle;
        end
      end
      StNewMul: begin
        res_d             = '0;
        res_d.start_tone  = 1'b1;
        res_d.tone_hz     = hz_prod;
        res_d.tone_ms     = note_len;
        res_d.played_slot = 6'(pos_q);
        if (rd_data_q.base != '0 && rd_data_q.oct != '0) begin
          state_d = StEmit;
        end else begin
          state_d = StIdle;
        end
      end
      StEmit: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_rsp_d   = res_q;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      tempo_q     <= TempoW'(TempoReset);
      song_len_q  <= 7'(SongLenReset);
      hold_q      <= 16'(HoldReset);
      pos_valid_q <= 1'b0;
      pos_q       <= '0;
      elapsed_q   <= '0;
      out_valid_q <= 1'b0;
      out_rsp_q   <= '0;
    end else begin
      state_q     <= state_d;
      tempo_q     <= tempo_d;
      song_len_q  <= song_len_d;
      hold_q      <= hold_d;
      pos_valid_q <= pos_valid_d;
      pos_q       <= pos_d;
      elapsed_q   <= elapsed_d;
      out_valid_q <= out_valid_d;
      out_rsp_q   <= out_rsp_d;
    end
  end

  // Length product, then the scaled terms of elapsed*20 > length*19
  always_ff @(posedge clk_i) begin
    len_prod_q <= len_prod;
    a19_q      <= {1'b0, len_prod_q[23:2], 4'b0} + {4'b0, len_prod_q[23:2], 1'b0}
                  + {5'b0, len_prod_q[23:2]};
    e20_q      <= {1'b0, elapsed_q, 4'b0} + {3'b0, elapsed_q, 2'b0};
    res_q      <= res_d;
  end

  // Song memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      song_mem[AddrW'(in_req_i.entry_slot)] <= '{
        len:  in_req_i.length_quarters,
        oct:  in_req_i.octave_factor,
        base: in_req_i.note_base
      };
    end
    rd_data_q <= song_mem[rd_addr];
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // Checks
  a_busy_blocks_in : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> in_stall_o)
    else $error("request taken while the divider runs");

  a_stop_idles : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_req_i.mode == ModeStop) |=> !pos_valid_q && elapsed_q == '0)
    else $error("stop did not idle the song");

  a_tempo_starts_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> div_busy)
    else $error("tempo write did not start the divider");

  a_tone_audible : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.start_tone) |-> (out_rsp_o.tone_hz != '0 && !out_rsp_o.silence))
    else $error("tone command without a frequency");

endmodule
